[rtl/swdr_pkg.sv]
// Shared types, sizes and key conversion for the sort-with-dense-rank block.
// No dependencies; used by swdr_cell and sort_with_dense_rank.
`timescale 1ns / 1ps

package swdr_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int KEY_BITS    = 32;

    localparam int IN_W        = 32;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int POS_W       = 6;
    localparam int CASE_W      = 7;
    localparam int RANK_W      = 7;
    localparam int OUT_FIELD_W = POS_W + CASE_W + RANK_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int EXT_W       = (KEY_BITS > IN_W) ? KEY_BITS : IN_W;

    typedef logic [KEY_BITS-1:0] t_key;

    typedef struct packed {
        t_key              key;
        logic [CASE_W-1:0] case_num;
    } t_cell;

    typedef enum logic {
        ST_LOAD,
        ST_UNLOAD
    } t_state;

    // Sign-extend the input word and keep the low KEY_BITS bits.
    function automatic t_key key_of(input logic [IN_W-1:0] value);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'($signed(value));
        return ext[KEY_BITS-1:0];
    endfunction

endpackage

[rtl/swdr_cell.sv]
// One cell of the insertion chain: holds a key and its case number.
// Depends on swdr_pkg (t_cell, t_key, CASE_W).
`timescale 1ns / 1ps

module swdr_cell (
    input  logic                      i_clk,
    input  logic                      i_ins,
    input  logic                      i_shift,
    input  logic                      i_occ,
    input  swdr_pkg::t_key            i_key,
    input  logic [swdr_pkg::CASE_W-1:0] i_case,
    input  swdr_pkg::t_cell           i_prev,
    input  logic                      i_prev_gt,
    input  swdr_pkg::t_cell           i_next,
    output swdr_pkg::t_cell           o_data,
    output logic                      o_gt
);

    swdr_pkg::t_cell r_data;

    // An empty cell counts as greater, so a key not below any stored key lands in the first free slot.
    assign o_gt   = !i_occ || ($signed(r_data.key) > $signed(i_key));
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ins && o_gt) begin
            if (i_prev_gt) begin
                r_data <= i_prev;
            end else begin
                r_data.key      <= i_key;
                r_data.case_num <= i_case;
            end
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

endmodule

[rtl/sort_with_dense_rank.sv]
// Top level: streaming insertion sorter with case number and dense rank.
// Depends on swdr_pkg and swdr_cell.
`timescale 1ns / 1ps

// Channel   Dir  tdata fields (low bit up)                           tuser  tlast
// s_axis    in   sample_value[31:0]                                  -      last_sample
// m_axis    out  sorted_position[5:0] case_number[12:6]               -      last_result
//                class_rank[19:13], zeros[23:20]
//
// Load: one word per cycle; each word is inserted into the cell chain in the
// cycle it is accepted (one compare per cell against the broadcast key).
// Unload: after the word marked last, the chain shifts toward cell 0 once per
// result taken. Input is held off (tready low) during unload.
// Reset clears the fill count, state, position and output valid; cells hold until written.

module sort_with_dense_rank (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [swdr_pkg::IN_W-1:0]       i_s_axis_tdata,  // sample_value
    input  logic                            i_s_axis_tlast,  // last_sample
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // sorted_position, case_number, class_rank, zero fill
    output logic [swdr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast   // last_result
);

    swdr_pkg::t_state              r_state, n_state;
    logic [swdr_pkg::CNT_W-1:0]    r_count, n_count;
    logic [swdr_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                          r_ovalid, n_ovalid;

    logic [swdr_pkg::POS_W-1:0]    r_out_pos;
    logic [swdr_pkg::CASE_W-1:0]   r_out_case;
    logic [swdr_pkg::RANK_W-1:0]   r_out_rank;
    logic                          r_out_last;
    swdr_pkg::t_key                r_prev_key;

    swdr_pkg::t_cell               w_cell [swdr_pkg::MAX_SAMPLES];
    logic                          w_gt   [swdr_pkg::MAX_SAMPLES];

    logic                          w_in_acc;
    logic                          w_ins;
    logic                          w_take;
    logic                          w_last;
    swdr_pkg::t_key                w_key;
    logic [swdr_pkg::CASE_W-1:0]   w_case;
    logic [swdr_pkg::RANK_W-1:0]   w_rank;

    assign o_s_axis_tready = (r_state == swdr_pkg::ST_LOAD);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    // Drop words beyond the chain length; their last mark still counts.
    assign w_ins           = w_in_acc
                             && (r_count < swdr_pkg::CNT_W'(swdr_pkg::MAX_SAMPLES));
    assign w_key           = swdr_pkg::key_of(i_s_axis_tdata);
    assign w_case          = swdr_pkg::CASE_W'(r_count + swdr_pkg::CNT_W'(1));

    // During unload, pull a word out of cell 0 whenever the output register is free.
    assign w_take = (r_state == swdr_pkg::ST_UNLOAD) && (r_count != '0)
                    && (!r_ovalid || i_m_axis_tready);
    assign w_last = (r_count == swdr_pkg::CNT_W'(1));

    // Dense rank: advance only on a strictly greater key than the previous one.
    always_comb begin
        if (r_pos == '0) begin
            w_rank = swdr_pkg::RANK_W'(1);
        end else if ($signed(w_cell[0].key) > $signed(r_prev_key)) begin
            w_rank = r_out_rank + swdr_pkg::RANK_W'(1);
        end else begin
            w_rank = r_out_rank;
        end
    end

    genvar g;
    generate
        for (g = 0; g < swdr_pkg::MAX_SAMPLES; g++) begin : g_cell
            swdr_pkg::t_cell w_prev;
            swdr_pkg::t_cell w_next;
            logic            w_prev_gt;

            if (g == 0) begin : g_head
                assign w_prev    = '0;
                assign w_prev_gt = 1'b0;
            end else begin : g_body
                assign w_prev    = w_cell[g-1];
                assign w_prev_gt = w_gt[g-1];
            end

            if (g == swdr_pkg::MAX_SAMPLES - 1) begin : g_tail
                assign w_next = w_cell[g];
            end else begin : g_mid
                assign w_next = w_cell[g+1];
            end

            swdr_cell u_cell (
                .i_clk     (i_clk),
                .i_ins     (w_ins),
                .i_shift   (w_take),
                .i_occ     (swdr_pkg::CNT_W'(g) < r_count),
                .i_key     (w_key),
                .i_case    (w_case),
                .i_prev    (w_prev),
                .i_prev_gt (w_prev_gt),
                .i_next    (w_next),
                .o_data    (w_cell[g]),
                .o_gt      (w_gt[g])
            );
        end
    endgenerate

    // Next state, fill count, position and output valid.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            swdr_pkg::ST_LOAD: begin
                if (w_ins) begin
                    n_count = r_count + swdr_pkg::CNT_W'(1);
                end
                if (w_in_acc && i_s_axis_tlast) begin
                    n_state = swdr_pkg::ST_UNLOAD;
                end
            end
            swdr_pkg::ST_UNLOAD: begin
                if (w_take) begin
                    n_ovalid = 1'b1;
                    n_count  = r_count - swdr_pkg::CNT_W'(1);
                    n_pos    = w_last ? '0 : r_pos + swdr_pkg::POS_W'(1);
                    if (w_last) begin
                        n_state = swdr_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = swdr_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= swdr_pkg::ST_LOAD;
            r_count  <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    // Output word and the key it carries.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_pos  <= r_pos;
            r_out_case <= w_cell[0].case_num;
            r_out_rank <= w_rank;
            r_out_last <= w_last;
            r_prev_key <= w_cell[0].key;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = swdr_pkg::OUT_DATA_W'({r_out_rank, r_out_case, r_out_pos});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= swdr_pkg::CNT_W'(swdr_pkg::MAX_SAMPLES))
        else $error("fill count exceeds chain length");

    a_last_starts_unload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> (r_state == swdr_pkg::ST_UNLOAD))
        else $error("last word did not start unload");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ((r_out_rank != '0)
                      && ({1'b0, r_out_rank} <= ({2'b0, r_out_pos} + 8'd1))))
        else $error("rank out of range for position");

    a_unload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swdr_pkg::ST_UNLOAD) |-> (r_count != '0))
        else $error("unload with empty chain");
`endif

endmodule

[tb/sv/sort_with_dense_rank_test.sv]
// Self-checking bench for sort_with_dense_rank: streams sample columns in,
// predicts sorted case numbers and dense ranks, checks every output word.
// Depends on swdr_pkg and sort_with_dense_rank.
`timescale 1ns / 1ps

module sort_with_dense_rank_test;
    import swdr_pkg::*;

    localparam int TARGET_WORDS     = 370;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 100;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int REPORT_LIMIT     = 10;

    // How the values of a generated column are chosen.
    typedef enum int {
        VALS_WIDE,       // anywhere in the 32-bit range
        VALS_CLUSTERED,  // -3..3, so ties are frequent
        VALS_EXTREME,    // min, max, zero, minus one
        VALS_MIXED       // a fresh pick of the above per word
    } value_style_t;

    typedef struct {
        logic [IN_W-1:0] value;
        logic            last;
        bit              wait_drain;  // hold this word until all results are in
        bit              hold_sink;   // start a long sink stall when accepted
    } sample_word_t;

    typedef struct {
        logic [POS_W-1:0]  pos;
        logic [CASE_W-1:0] case_num;
        logic [RANK_W-1:0] rank;
        logic              last;
    } ranked_word_t;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;   // sample_value
    logic                  s_tlast  = 1'b0; // last_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // sorted_position, case_number, class_rank, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;         // last_result

    sample_word_t            pending_words[$];
    sample_word_t            offered;
    ranked_word_t            expected_ranks[$];
    logic signed [IN_W-1:0]  column_keys[$];

    int   total_words = 1;
    int   words_sent  = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;
    int   hold_left   = 0;
    logic hold_go     = 1'b0;

    sort_with_dense_rank dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic logic [IN_W-1:0] pick_value(input value_style_t style);
        case (style)
            VALS_WIDE: begin
                return $urandom;
            end
            VALS_CLUSTERED: begin
                return IN_W'(int'($urandom_range(6)) - 3);
            end
            VALS_EXTREME: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: begin
                return pick_value(value_style_t'($urandom_range(2)));
            end
        endcase
    endfunction

    task automatic add_word(input logic [IN_W-1:0] value, input logic last,
                            input bit drain = 1'b0, input bit hold = 1'b0);
        sample_word_t w;
        w.value      = value;
        w.last       = last;
        w.wait_drain = drain;
        w.hold_sink  = hold;
        pending_words.push_back(w);
    endtask

    // Only the first word carries the drain and hold marks.
    task automatic add_column(input int len, input value_style_t style,
                              input bit drain, input bit hold);
        for (int i = 0; i < len; i++)
            add_word(pick_value(style), i == len - 1, drain && i == 0, hold && i == 0);
    endtask

    // Mostly short columns, now and then a longer one.
    task automatic add_random_column();
        int len;
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        add_column(len, value_style_t'($urandom_range(3)), $urandom_range(19) == 0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Prediction: collect the column, then on the last word do a stable
    // insertion sort of arrival slots and walk it for the dense rank.
    // ------------------------------------------------------------------
    task automatic absorb_sample(input logic [IN_W-1:0] value, input logic last);
        int           order[$];
        int           j;
        int           rank;
        ranked_word_t r;
        // drop words beyond capacity; they get no case number
        if (column_keys.size() < MAX_SAMPLES)
            column_keys.push_back(value);
        if (!last)
            return;
        for (int i = 0; i < column_keys.size(); i++) begin
            j = order.size();
            // strict compare keeps equal keys in arrival order
            while (j > 0 && column_keys[order[j-1]] > column_keys[i])
                j--;
            order.insert(j, i);
        end
        rank = 1;
        for (int i = 0; i < order.size(); i++) begin
            if (i > 0 && column_keys[order[i]] > column_keys[order[i-1]])
                rank++;
            r.pos      = POS_W'(i);
            r.case_num = CASE_W'(order[i] + 1);
            r.rank     = RANK_W'(rank);
            r.last     = (i == order.size() - 1);
            expected_ranks.push_back(r);
        end
        column_keys.delete();
    endtask

    // Idle rates per thirds of the run: sender light / sink heavy, swapped, none.
    function automatic int sender_idle_pct();
        if (words_sent < total_words / 3)
            return 24;
        else if (words_sent < 2 * total_words / 3)
            return 64;
        return 0;
    endfunction

    function automatic int sink_idle_pct();
        if (words_sent < total_words / 3)
            return 64;
        else if (words_sent < 2 * total_words / 3)
            return 24;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present one word at a time, advance on handshake.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            hold_go  <= 1'b0;
        end else begin
            hold_go <= s_tvalid && s_tready && offered.hold_sink;
            if (s_tvalid && s_tready) begin
                absorb_sample(offered.value, offered.last);
                words_sent <= words_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                // hold a drain-marked word back until the previous columns are out
                if (pending_words.size() != 0
                    && !(pending_words[0].wait_drain && expected_ranks.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct()) begin
                    offered = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.value;
                    s_tlast  <= offered.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long sink stall, kicked off by a marked input word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= SINK_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken word against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int want, input int got);
        if (mismatches < REPORT_LIMIT)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        mismatches++;
    endtask

    task automatic check_result();
        ranked_word_t want;
        ranked_word_t got;
        got.pos      = m_tdata[POS_W-1:0];
        got.case_num = m_tdata[POS_W+CASE_W-1:POS_W];
        got.rank     = m_tdata[OUT_FIELD_W-1:POS_W+CASE_W];
        got.last     = m_tlast;
        if (expected_ranks.size() == 0) begin
            note_mismatch("unexpected word, position", -1, got.pos);
            return;
        end
        want = expected_ranks.pop_front();
        if (got.pos != want.pos)
            note_mismatch("sorted_position", want.pos, got.pos);
        if (got.case_num != want.case_num)
            note_mismatch("case_number", want.case_num, got.case_num);
        if (got.rank != want.rank)
            note_mismatch("class_rank", want.rank, got.rank);
        if (got.last != want.last)
            note_mismatch("last_result", want.last, got.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct());
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // single-sample columns at both extremes: rank 1, case 1
        add_word(32'h8000_0000, 1'b1);
        add_word(32'h7fff_ffff, 1'b1);
        // extremes with ties: equal keys keep arrival order
        add_word(32'h7fff_ffff, 1'b0);
        add_word(32'h8000_0000, 1'b0);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'hffff_ffff, 1'b0);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'h8000_0000, 1'b0);
        add_word(32'h7fff_ffff, 1'b1);
        // all equal: one rank for the whole column
        add_word(32'd5, 1'b0);
        add_word(32'd5, 1'b0);
        add_word(32'd5, 1'b1);
        // strictly descending, crossing zero
        add_word(32'd3, 1'b0);
        add_word(32'd2, 1'b0);
        add_word(32'd1, 1'b0);
        add_word(32'hffff_ffff, 1'b1);
        // already ascending
        add_word(32'd1, 1'b0);
        add_word(32'd2, 1'b1);

        while (pending_words.size() < 120)
            add_random_column();
        // full column with the sink stalled from its first word into its unload; the sender keeps
        // offering the next column, so the input stalls as well
        add_column(MAX_SAMPLES, VALS_MIXED, 1'b1, 1'b1);
        while (pending_words.size() < 250)
            add_random_column();
        // overlong column: extra words are dropped, the last mark still closes it
        add_column(MAX_SAMPLES + 6, VALS_CLUSTERED, 1'b1, 1'b0);
        while (pending_words.size() < TARGET_WORDS)
            add_random_column();
        total_words = pending_words.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid || expected_ranks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_ranks.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
